>>> hw/rtl/ssts_pkg.sv
// Shared types, constants and decimal lookup tables for the seven-segment telemetry scanner.
// No dependencies; used by ssts_store, ssts_decode and the top level.
package ssts_pkg;

    // Display position code, wide enough for every scan slot
    localparam int POS_W = 3;
    typedef logic [POS_W-1:0] pos_t;

    // Named scan positions
    localparam pos_t POS_ANGLE_ONES     = 3'd0;
    localparam pos_t POS_ANGLE_TENS     = 3'd1;
    localparam pos_t POS_ANGLE_HUNDREDS = 3'd2;
    localparam pos_t POS_MINUS          = 3'd3;
    localparam pos_t POS_SPEED_ONES     = 3'd4;
    localparam pos_t POS_SPEED_TENS     = 3'd5;
    localparam pos_t POS_SPEED_HUNDREDS = 3'd6;

    // Command codes on the input word
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Active-low segment codes, bit 7 is the decimal point
    localparam logic [7:0] SEG_DP_MASK = 8'h7f;
    localparam logic [7:0] SEG_MINUS   = 8'hbf;
    localparam logic [7:0] SEG_BLANK   = 8'hff;

    typedef logic [7:0] seg_table_t [10];
    localparam seg_table_t SEG_DIGITS = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
    };

    // Digit select per position (one-hot, board wiring order)
    typedef logic [7:0] sel_table_t [7];
    localparam sel_table_t POS_SELECT = '{
        8'h10, 8'h20, 8'h40, 8'h80, 8'h01, 8'h02, 8'h04
    };

    // Stored display digits in BCD, plus the reverse flag
    typedef struct packed {
        logic [3:0] angle_hundreds;
        logic [3:0] angle_tens;
        logic [3:0] angle_ones;
        logic       reverse;
        logic [3:0] speed_hundreds;
        logic [3:0] speed_tens;
        logic [3:0] speed_ones;
    } digits_t;

    // BCD of angle in tenths: (a & 0x7f) * 18, thousands digit dropped
    typedef logic [11:0] angle_bcd_table_t [128];
    // BCD of speed: byte * 2
    typedef logic [11:0] speed_bcd_table_t [256];

    function automatic angle_bcd_table_t build_angle_bcd();
        angle_bcd_table_t t;
        int v;
        for (int i = 0; i < 128; i++) begin
            v = i * 18;
            t[i] = {4'((v % 1000) / 100), 4'((v % 100) / 10), 4'(v % 10)};
        end
        return t;
    endfunction

    function automatic speed_bcd_table_t build_speed_bcd();
        speed_bcd_table_t t;
        int v;
        for (int i = 0; i < 256; i++) begin
            v = i * 2;
            t[i] = {4'((v % 1000) / 100), 4'((v % 100) / 10), 4'(v % 10)};
        end
        return t;
    endfunction

    localparam angle_bcd_table_t ANGLE_BCD = build_angle_bcd();
    localparam speed_bcd_table_t SPEED_BCD = build_speed_bcd();

    // Digit to segment pattern; codes above nine never occur
    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] p;
        if (d < 4'd10) begin
            p = SEG_DIGITS[d];
        end else begin
            p = SEG_BLANK;
        end
        return p;
    endfunction

endpackage

>>> hw/rtl/seven_segment_telemetry_scanner.sv
// Seven-segment telemetry scanner: takes one word per cycle while the output is not
// stalled and returns one display word per scan tick; an update word (command 1) loads
// speed and angle and returns nothing. Each word passes an input register and, for ticks,
// an output register, which holds the tick's display word on the m_ ports. While m_ready
// holds, the sustained rate is one word per cycle in and one display word per tick out;
// the output register lets the next word enter while a result waits for m_ready. Updates
// take effect for every tick that follows them. Ticks step through seven positions:
// angle ones, tens with decimal point, hundreds (blank when zero), minus sign (only in
// reverse), speed ones, tens (blank below ten), hundreds (blank when zero). Segments are
// active low; digit_enable is zero for a blanked position.
// Depends on ssts_pkg, ssts_store and ssts_decode.
module seven_segment_telemetry_scanner #(
    parameter int POSITION_COUNT = 7
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_angle_byte,
    input  logic [7:0] s_speed_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_digit_enable,
    output logic [7:0] m_segment_pattern
);
    import ssts_pkg::*;

    localparam int CNT_W = $clog2(POSITION_COUNT);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(POSITION_COUNT - 1);

    // Input register
    logic       in_valid_reg;
    logic       in_command_reg;
    logic [7:0] in_angle_reg;
    logic [7:0] in_speed_reg;

    // Output register
    logic       out_valid_reg;
    logic [7:0] out_enable_reg;
    logic [7:0] out_pattern_reg;

    logic [CNT_W-1:0] pos_reg;
    logic [CNT_W-1:0] pos_next;

    logic       out_free;
    logic       advance;
    logic       tick_fire;
    logic       update_fire;
    digits_t    digits;
    logic [7:0] dec_enable;
    logic [7:0] dec_pattern;

    // Handshake: an update always leaves; a tick needs room in the output register
    assign out_free    = !out_valid_reg || m_ready;
    assign advance     = in_valid_reg && ((in_command_reg == CMD_UPDATE) || out_free);
    assign tick_fire   = advance && (in_command_reg == CMD_TICK);
    assign update_fire = advance && (in_command_reg == CMD_UPDATE);
    assign s_ready     = !in_valid_reg || advance;

    assign pos_next = (pos_reg >= LAST_POS) ? '0 : pos_reg + 1'b1;

    ssts_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (update_fire),
        .angle_byte (in_angle_reg),
        .speed_byte (in_speed_reg),
        .digits     (digits)
    );

    ssts_decode u_decode (
        .pos             (pos_t'(pos_reg)),
        .digits          (digits),
        .digit_enable    (dec_enable),
        .segment_pattern (dec_pattern)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (tick_fire) begin
                out_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_command_reg <= s_command;
            in_angle_reg   <= s_angle_byte;
            in_speed_reg   <= s_speed_byte;
        end
        if (tick_fire) begin
            out_enable_reg  <= dec_enable;
            out_pattern_reg <= dec_pattern;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_digit_enable    = out_enable_reg;
    assign m_segment_pattern = out_pattern_reg;

endmodule

>>> hw/rtl/ssts_store.sv
// Telemetry store: converts an update word to BCD display digits and holds them.
// Depends on ssts_pkg for the digit struct and the conversion tables.
module ssts_store (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [7:0]        angle_byte,
    input  logic [7:0]        speed_byte,
    output ssts_pkg::digits_t digits
);
    import ssts_pkg::*;

    digits_t    digits_reg;
    digits_t    digits_next;
    logic [11:0] angle_bcd;
    logic [11:0] speed_bcd;

    // Table lookups for the decimal digits
    always_comb begin
        angle_bcd = ANGLE_BCD[angle_byte[6:0]];
        speed_bcd = SPEED_BCD[speed_byte];
        digits_next.angle_hundreds = angle_bcd[11:8];
        digits_next.angle_tens     = angle_bcd[7:4];
        digits_next.angle_ones     = angle_bcd[3:0];
        digits_next.reverse        = angle_byte[7];
        digits_next.speed_hundreds = speed_bcd[11:8];
        digits_next.speed_tens     = speed_bcd[7:4];
        digits_next.speed_ones     = speed_bcd[3:0];
    end

    // Digit registers, zero after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_reg <= '0;
        end else if (wr_en) begin
            digits_reg <= digits_next;
        end
    end

    assign digits = digits_reg;

endmodule

>>> hw/rtl/ssts_decode.sv
// Position decoder: picks the digit and segment pattern for one scan position.
// Depends on ssts_pkg for segment codes, position codes and the digit struct.
module ssts_decode (
    input  ssts_pkg::pos_t    pos,
    input  ssts_pkg::digits_t digits,
    output logic [7:0]        digit_enable,
    output logic [7:0]        segment_pattern
);
    import ssts_pkg::*;

    logic show;

    // Pattern and blanking per position
    always_comb begin
        segment_pattern = SEG_BLANK;
        show            = 1'b0;
        case (pos)
            POS_ANGLE_ONES: begin
                segment_pattern = seg_of(digits.angle_ones);
                show            = 1'b1;
            end
            POS_ANGLE_TENS: begin
                segment_pattern = seg_of(digits.angle_tens) & SEG_DP_MASK;
                show            = 1'b1;
            end
            POS_ANGLE_HUNDREDS: begin
                segment_pattern = seg_of(digits.angle_hundreds);
                show            = (digits.angle_hundreds != 4'd0);
            end
            POS_MINUS: begin
                segment_pattern = SEG_MINUS;
                show            = digits.reverse;
            end
            POS_SPEED_ONES: begin
                segment_pattern = seg_of(digits.speed_ones);
                show            = 1'b1;
            end
            POS_SPEED_TENS: begin
                // blank only when the whole speed is below ten
                segment_pattern = seg_of(digits.speed_tens);
                show            = (digits.speed_tens != 4'd0) ||
                                  (digits.speed_hundreds != 4'd0);
            end
            POS_SPEED_HUNDREDS: begin
                segment_pattern = seg_of(digits.speed_hundreds);
                show            = (digits.speed_hundreds != 4'd0);
            end
            default: begin
                segment_pattern = SEG_BLANK;
                show            = 1'b0;
            end
        endcase
    end

    assign digit_enable = (show && (pos <= POS_SPEED_HUNDREDS)) ? POS_SELECT[pos] : 8'h00;

endmodule

>>> test/tb.sv
// Self-checking bench for seven_segment_telemetry_scanner: queued words drive the input
// channel, a model of the display scan predicts each digit word, a monitor checks it.
// Depends on ssts_pkg and the scanner RTL.
`timescale 1ns / 1ps

module tb;
    import ssts_pkg::*;

    localparam int NUM_RANDOM = 1150;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic       command;
        logic [7:0] angle_byte;
        logic [7:0] speed_byte;
    } scan_word_t;

    typedef struct {
        logic [7:0] digit_enable;
        logic [7:0] segment_pattern;
    } digit_word_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_command;
    logic [7:0] s_angle_byte;
    logic [7:0] s_speed_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_digit_enable;
    logic [7:0] m_segment_pattern;

    scan_word_t  pending_words[$];
    digit_word_t expected_digits[$];
    scan_word_t  next_word;
    digit_word_t seen_digit;

    int words_queued;
    int words_taken;
    int send_idle_pct;
    int recv_stall_pct;
    int error_count;

    // Shadow copy of the display state
    pos_t       scan_pos;
    logic [8:0] speed_shadow;
    logic [11:0] angle_shadow;
    logic       reverse_shadow;

    seven_segment_telemetry_scanner dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_angle_byte      (s_angle_byte),
        .s_speed_byte      (s_speed_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_digit_enable    (m_digit_enable),
        .m_segment_pattern (m_segment_pattern)
    );

    always #4 aclk = ~aclk;

    // Segment code of one decimal digit
    function automatic logic [7:0] digit_segments(input int d);
        logic [7:0] seg_codes [10];
        seg_codes = '{8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90};
        return seg_codes[d];
    endfunction

    // Apply one accepted word to the shadow state; ticks queue the expected digit word
    task automatic scan_display(input scan_word_t w);
        digit_word_t r;
        int          angle;
        int          speed;
        int          d;
        logic        lit;
        logic [7:0]  sel;
        angle = int'(angle_shadow);
        speed = int'(speed_shadow);
        lit = 1'b0;
        if (w.command == CMD_UPDATE) begin
            speed_shadow = {w.speed_byte, 1'b0};
            angle_shadow = 12'(int'(w.angle_byte[6:0]) * 18);
            reverse_shadow = w.angle_byte[7];
        end else begin
            r.segment_pattern = SEG_BLANK;
            case (scan_pos)
                POS_ANGLE_ONES: begin
                    r.segment_pattern = digit_segments(angle % 10);
                    lit = 1'b1;
                end
                POS_ANGLE_TENS: begin
                    r.segment_pattern = digit_segments((angle % 100) / 10) & SEG_DP_MASK;
                    lit = 1'b1;
                end
                POS_ANGLE_HUNDREDS: begin
                    d = (angle % 1000) / 100;
                    r.segment_pattern = digit_segments(d);
                    lit = (d > 0);
                end
                POS_MINUS: begin
                    r.segment_pattern = SEG_MINUS;
                    lit = reverse_shadow;
                end
                POS_SPEED_ONES: begin
                    r.segment_pattern = digit_segments(speed % 10);
                    lit = 1'b1;
                end
                POS_SPEED_TENS: begin
                    r.segment_pattern = digit_segments((speed % 100) / 10);
                    lit = (speed >= 10);
                end
                POS_SPEED_HUNDREDS: begin
                    d = (speed % 1000) / 100;
                    r.segment_pattern = digit_segments(d);
                    lit = (d > 0);
                end
                default: lit = 1'b0;
            endcase
            case (scan_pos)
                POS_ANGLE_ONES:     sel = 8'h10;
                POS_ANGLE_TENS:     sel = 8'h20;
                POS_ANGLE_HUNDREDS: sel = 8'h40;
                POS_MINUS:          sel = 8'h80;
                POS_SPEED_ONES:     sel = 8'h01;
                POS_SPEED_TENS:     sel = 8'h02;
                POS_SPEED_HUNDREDS: sel = 8'h04;
                default:            sel = 8'h00;
            endcase
            r.digit_enable = lit ? sel : 8'h00;
            expected_digits.push_back(r);
            if (int'(scan_pos) + 1 >= 7) begin
                scan_pos = POS_ANGLE_ONES;
            end else begin
                scan_pos = scan_pos + 1'b1;
            end
        end
    endtask

    task automatic queue_word(input logic cmd, input logic [7:0] ab, input logic [7:0] sb);
        scan_word_t w;
        w.command = cmd;
        w.angle_byte = ab;
        w.speed_byte = sb;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic wait_words_taken();
        while (words_taken != words_queued) @(posedge aclk);
    endtask

    // Input driver: hold a word until taken, then maybe idle, then present the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                next_word.command = s_command;
                next_word.angle_byte = s_angle_byte;
                next_word.speed_byte = s_speed_byte;
                scan_display(next_word);
                words_taken++;
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = pending_words.pop_front();
                    s_valid <= 1'b1;
                    s_command <= next_word.command;
                    s_angle_byte <= next_word.angle_byte;
                    s_speed_byte <= next_word.speed_byte;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: random backpressure, compare each digit word with the oldest expectation
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_digits.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected word: enable %h pattern %h",
                             m_digit_enable, m_segment_pattern);
            end else begin
                seen_digit = expected_digits.pop_front();
                if (m_digit_enable !== seen_digit.digit_enable ||
                        m_segment_pattern !== seen_digit.segment_pattern) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch: enable exp %h got %h, pattern exp %h got %h",
                                 seen_digit.digit_enable, m_digit_enable,
                                 seen_digit.segment_pattern, m_segment_pattern);
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int pct_send [4];
        int pct_recv [4];
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = CMD_TICK;
        s_angle_byte = 8'h00;
        s_speed_byte = 8'h00;
        m_ready = 1'b0;
        words_queued = 0;
        words_taken = 0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        scan_pos = POS_ANGLE_ONES;
        speed_shadow = '0;
        angle_shadow = '0;
        reverse_shadow = 1'b0;
        pct_send = '{0, 54, 0, 31};
        pct_recv = '{0, 0, 54, 31};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset state: zero angle and speed, most positions blank
        for (int i = 0; i < 7; i++) queue_word(CMD_TICK, 8'hff, 8'hff);
        // Largest values: angle 228.6 with thousands dropped, speed 510, reverse
        queue_word(CMD_UPDATE, 8'hff, 8'hff);
        for (int i = 0; i < 7; i++) queue_word(CMD_TICK, 8'h00, 8'h00);
        // Speed 104: tens digit zero but still shown; angle 9.0 reverse
        queue_word(CMD_UPDATE, 8'h85, 8'd52);
        for (int i = 0; i < 7; i++) queue_word(CMD_TICK, 8'($urandom_range(255)),
                                               8'($urandom_range(255)));
        wait_words_taken();

        // Random phases with different idle and stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = pct_send[ph];
            recv_stall_pct = pct_recv[ph];
            for (int i = 0; i < NUM_RANDOM / 4; i++) begin
                if ($urandom_range(99) < 20)
                    queue_word(CMD_UPDATE, 8'($urandom_range(255)), 8'($urandom_range(255)));
                else
                    queue_word(CMD_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            wait_words_taken();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (expected_digits.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (error_count == 0 && expected_digits.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("timeout with %0d words waiting", expected_digits.size());
        $display("status: fail");
        $finish;
    end

endmodule
